### rtl/ssd_pkg.sv
// Shared types, widths and constants for the seven-segment scan driver.
// Used by ssd_encode, ssd_frame_seq and the top level; depends on nothing.
package ssd_pkg;

    localparam int VALUE_W   = 14;
    localparam int SYM_W     = 5;
    localparam int SEG_W     = 8;
    localparam int SEL_W     = 2;
    localparam int DWELL_W   = 20;
    localparam int MUL_W     = VALUE_W + 2;
    localparam int EMIT_CAP  = 4;
    localparam int SYM_COUNT = 18;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 20'd72000;
    localparam logic [SEG_W-1:0]   DOT_BIT     = 8'h80;

    typedef enum logic {
        REQ_NUMBER = 1'b0,
        REQ_SYMBOL = 1'b1
    } t_req;

    // hex digits 0-f, then minus, then blank
    localparam logic [SEG_W-1:0] SEG_TABLE [SYM_COUNT] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71,
        8'h40, 8'h00
    };

    // One decoded request, ready for the frame sequencer.
    typedef struct packed {
        logic                              keep;
        logic                              sym;
        logic [SEL_W-1:0]                  pos;
        logic [SEL_W-1:0]                  last_dig;
        logic [EMIT_CAP-1:0][SEG_W-1:0]    seg;
    } t_run;

    function automatic logic [SEG_W-1:0] seg_of(input logic [SYM_W-1:0] s);
        logic [SEG_W-1:0] r;
        r = '0;
        if (s < SYM_W'(SYM_COUNT)) begin
            r = SEG_TABLE[s];
        end
        return r;
    endfunction

    function automatic longint unsigned pow10(input int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

### rtl/seven_segment_scan_driver.sv
// Top level of the seven-segment scan driver: dwell register, request
// decode and frame sequencing. Depends on ssd_pkg, ssd_encode, ssd_frame_seq.
//
// Usage:
//   Requests enter on i_valid/o_ready with i_req_type, i_value, i_digit_pos,
//   i_symbol and i_dot_on. A number request yields a segment frame and a
//   blanking frame for each shown digit (DIGITS, capped at four); a symbol
//   request yields one pair. A symbol above 17 yields no frame at all.
//   Frames leave on o_valid/i_ready; o_last_of_run marks a run's final beat.
//   i_cfg_we writes i_cfg_wdata into the dwell count; write it only while idle.
//   A request passes the decode's input and quotient registers, the run
//   register and the output register before its first segment beat. Each
//   digit presents the segment frame, counts the dwell down in the dwell
//   counter, presents the blank and returns to idle before the next digit;
//   the dwell counter sets the rate. Decode takes new requests every cycle
//   while o_ready is high and buffers up to two behind the run being shown.
//   A stalled receiver holds the current frame; the dwell starts only when
//   the segment beat is taken. Reset empties all stages and loads the
//   dwell count with 72000.
module seven_segment_scan_driver import ssd_pkg::*; #(
    parameter int unsigned DIGITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DWELL_W-1:0] i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [SEL_W-1:0]   i_digit_pos,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic               i_dot_on,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEL_W-1:0]   o_digit_select,
    output logic [SEG_W-1:0]   o_segment_byte,
    output logic               o_is_blank,
    output logic               o_last_of_run
);

    logic [DWELL_W-1:0] r_dwell_cycles;
    logic               w_run_valid;
    logic               w_run_ready;
    t_run               w_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_cycles <= DWELL_RESET;
        end else if (i_cfg_we) begin
            r_dwell_cycles <= i_cfg_wdata;
        end
    end

    ssd_encode #(
        .DIGITS (DIGITS)
    ) u_encode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_digit_pos (i_digit_pos),
        .i_symbol    (i_symbol),
        .i_dot_on    (i_dot_on),
        .o_valid     (w_run_valid),
        .i_ready     (w_run_ready),
        .o_run       (w_run)
    );

    ssd_frame_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_run_valid    (w_run_valid),
        .o_run_ready    (w_run_ready),
        .i_run          (w_run),
        .i_dwell        (r_dwell_cycles),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digit_select (o_digit_select),
        .o_segment_byte (o_segment_byte),
        .o_is_blank     (o_is_blank),
        .o_last_of_run  (o_last_of_run)
    );

    // a run always ends on a blanking beat
    a_last_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_run |-> o_is_blank)
        else $error("last_of_run on a segment beat");

    // the dwell separates a taken segment beat from its blank
    a_dwell_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_is_blank |=> !o_valid)
        else $error("blank beat without dwell gap");

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_blank |-> o_segment_byte == '0)
        else $error("blanking beat carries lit segments");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

### rtl/ssd_encode.sv
// Request decode: saturation, decimal digit split by reciprocal multiply,
// and segment lookup. Two register stages; depends on ssd_pkg.
module ssd_encode import ssd_pkg::*; #(
    parameter int unsigned DIGITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [SEL_W-1:0]   i_digit_pos,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic               i_dot_on,
    output logic               o_valid,
    input  logic               i_ready,
    output t_run               o_run
);

    localparam int NEMIT = (DIGITS < EMIT_CAP) ? DIGITS : EMIT_CAP;
    localparam longint unsigned LIMIT = pow10(DIGITS) - 1;
    localparam longint unsigned VMAX  = (64'd1 << VALUE_W) - 1;
    localparam logic [VALUE_W-1:0] SAT_V = VALUE_W'((LIMIT < VMAX) ? LIMIT : VMAX);

    logic               r_in_vld;
    logic               r_in_req;
    logic [VALUE_W-1:0] r_in_val;
    logic [SEL_W-1:0]   r_in_pos;
    logic [SYM_W-1:0]   r_in_sym;
    logic               r_in_dot;

    logic               r_q_vld;
    logic               r_q_req;
    logic [SEL_W-1:0]   r_q_pos;
    logic [SYM_W-1:0]   r_q_sym;
    logic               r_q_dot;
    logic [VALUE_W-1:0] r_q [NEMIT];

    logic [VALUE_W-1:0] w_q [NEMIT];
    logic [3:0]         w_dig [NEMIT];
    logic               w_adv1;
    logic [VALUE_W-1:0] n_val;

    assign w_adv1  = r_in_vld && (!r_q_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv1;
    assign o_valid = r_q_vld;
    assign n_val   = (i_value > SAT_V) ? SAT_V : i_value;

    // floor(v / 10^k) as (v * m) >> s, exact for every 14-bit v
    for (genvar j = 0; j < NEMIT; j++) begin : g_quot
        localparam longint unsigned D = pow10(int'(DIGITS) - 1 - j);
        localparam int L = $clog2(D);
        localparam int S = VALUE_W + L;
        localparam longint unsigned M = ((64'd1 << S) + D - 1) / D;
        localparam logic [MUL_W-1:0] MK = MUL_W'(M);
        logic [VALUE_W+MUL_W-1:0] w_prod;
        assign w_prod = r_in_val * MK;
        assign w_q[j] = VALUE_W'(w_prod >> S);
    end

    // digit = q[j] - 10 * q[j-1]; the top quotient is already one digit
    for (genvar j = 0; j < NEMIT; j++) begin : g_dig
        if (j == 0) begin : g_top
            assign w_dig[j] = r_q[j][3:0];
        end else begin : g_low
            logic [VALUE_W-1:0] w_diff;
            assign w_diff = r_q[j] - {r_q[j-1][VALUE_W-4:0], 3'b000}
                                   - {r_q[j-1][VALUE_W-2:0], 1'b0};
            assign w_dig[j] = w_diff[3:0];
        end
    end

    always_comb begin
        o_run          = '0;
        o_run.pos      = r_q_pos;
        if (r_q_req == REQ_SYMBOL) begin
            o_run.sym      = 1'b1;
            o_run.keep     = (r_q_sym < SYM_W'(SYM_COUNT));
            o_run.last_dig = '0;
            o_run.seg[0]   = seg_of(r_q_sym) | (r_q_dot ? DOT_BIT : '0);
        end else begin
            o_run.sym      = 1'b0;
            o_run.keep     = 1'b1;
            o_run.last_dig = SEL_W'(NEMIT - 1);
            for (int j = 0; j < NEMIT; j++) begin
                o_run.seg[j] = seg_of({1'b0, w_dig[j]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_q_vld  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (!r_q_vld || i_ready) begin
                r_q_vld <= r_in_vld;
            end
        end
        if (i_valid && o_ready) begin
            r_in_req <= i_req_type;
            r_in_val <= n_val;
            r_in_pos <= i_digit_pos;
            r_in_sym <= i_symbol;
            r_in_dot <= i_dot_on;
        end
        if (w_adv1) begin
            r_q_req <= r_in_req;
            r_q_pos <= r_in_pos;
            r_q_sym <= r_in_sym;
            r_q_dot <= r_in_dot;
            for (int j = 0; j < NEMIT; j++) begin
                r_q[j] <= w_q[j];
            end
        end
    end

endmodule

### rtl/ssd_frame_seq.sv
// Frame sequencer: walks a decoded run, emitting a segment frame, holding
// it for the dwell count, then a blanking frame per digit. Uses ssd_pkg.
module ssd_frame_seq import ssd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_run_valid,
    output logic               o_run_ready,
    input  t_run               i_run,
    input  logic [DWELL_W-1:0] i_dwell,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEL_W-1:0]   o_digit_select,
    output logic [SEG_W-1:0]   o_segment_byte,
    output logic               o_is_blank,
    output logic               o_last_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEG,
        ST_DWELL,
        ST_BLANK
    } t_state;

    t_state             r_state;
    t_run               r_run;
    logic               r_run_vld;
    logic [SEL_W-1:0]   r_dig;
    logic [DWELL_W-1:0] r_cnt;
    logic               r_o_vld;
    logic [SEL_W-1:0]   r_o_sel;
    logic [SEG_W-1:0]   r_o_seg;
    logic               r_o_blank;
    logic               r_o_last;

    logic               w_fin;
    logic [SEL_W-1:0]   w_sel;

    assign w_fin       = (r_state == ST_BLANK) && i_ready && r_o_last;
    assign o_run_ready = !r_run_vld || w_fin;
    assign w_sel       = r_run.sym ? r_run.pos : r_dig;

    assign o_valid        = r_o_vld;
    assign o_digit_select = r_o_sel;
    assign o_segment_byte = r_o_seg;
    assign o_is_blank     = r_o_blank;
    assign o_last_of_run  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_run_vld <= 1'b0;
            r_o_vld   <= 1'b0;
            r_dig     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (r_run_vld) begin
                        r_o_vld   <= 1'b1;
                        r_o_sel   <= w_sel;
                        r_o_seg   <= r_run.seg[r_dig];
                        r_o_blank <= 1'b0;
                        r_o_last  <= 1'b0;
                        r_state   <= ST_SEG;
                    end
                end
                ST_SEG: begin
                    // segment beat latched: start the dwell
                    if (i_ready) begin
                        r_o_vld <= 1'b0;
                        r_cnt   <= i_dwell;
                        r_state <= ST_DWELL;
                    end
                end
                ST_DWELL: begin
                    if (r_cnt == '0) begin
                        r_o_vld   <= 1'b1;
                        r_o_seg   <= '0;
                        r_o_blank <= 1'b1;
                        r_o_last  <= (r_dig == r_run.last_dig);
                        r_state   <= ST_BLANK;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_BLANK: begin
                    if (i_ready) begin
                        r_o_vld <= 1'b0;
                        r_state <= ST_IDLE;
                        if (r_o_last) begin
                            r_dig <= '0;
                        end else begin
                            r_dig <= r_dig + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // take the next run; drop requests that show nothing
            if (i_run_valid && o_run_ready) begin
                r_run_vld <= i_run.keep;
            end else if (w_fin) begin
                r_run_vld <= 1'b0;
            end
        end
        if (i_run_valid && o_run_ready) begin
            r_run <= i_run;
        end
    end

endmodule

### sim/tb_top.sv
// Self-checking testbench for seven_segment_scan_driver: directed and random requests and frame checks.
// Depends on rtl/ssd_pkg.sv and rtl/seven_segment_scan_driver.sv.
module tb_top;
    import ssd_pkg::*;

    localparam int unsigned SHOWN_DIGITS = 4;
    localparam int unsigned NUMBER_MAX   = 9999;
    localparam int unsigned SYM_MINUS    = 16;
    localparam int unsigned SYM_BLANK    = 17;
    localparam int unsigned DWELL_MAX    = 1048575;
    localparam int unsigned PER_PHASE    = 51;
    localparam int unsigned SETTLE       = 16;
    localparam int unsigned DRAIN        = 40;
    localparam int unsigned CYCLE_LIMIT  = 5000000;

    typedef struct {
        t_req               req;
        logic [VALUE_W-1:0] value;
        logic [SEL_W-1:0]   pos;
        logic [SYM_W-1:0]   sym;
        logic               dot;
    } t_request;

    typedef struct {
        logic [SEL_W-1:0] sel;
        logic [SEG_W-1:0] seg;
        logic             blank;
        logic             last;
    } t_frame;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [DWELL_W-1:0] i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_req_type = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic [SEL_W-1:0]   i_digit_pos = '0;
    logic [SYM_W-1:0]   i_symbol = '0;
    logic               i_dot_on = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b1;
    logic [SEL_W-1:0]   o_digit_select;
    logic [SEG_W-1:0]   o_segment_byte;
    logic               o_is_blank;
    logic               o_last_of_run;

    t_request    backlog[$];
    t_frame      frames_due[$];
    logic        req_taken = 1'b0;
    logic        beat_taken = 1'b0;
    int unsigned gap_cap = 7;
    int unsigned stall_cap = 7;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned n_requests = 0;
    int unsigned n_ignored = 0;
    int unsigned n_saturated = 0;
    int unsigned n_frames = 0;
    int unsigned n_dwell_writes = 0;

    seven_segment_scan_driver DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_digit_pos    (i_digit_pos),
        .i_symbol       (i_symbol),
        .i_dot_on       (i_dot_on),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digit_select (o_digit_select),
        .o_segment_byte (o_segment_byte),
        .o_is_blank     (o_is_blank),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames still due", cycles, frames_due.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [SEG_W-1:0] segment_glyph(input logic [SYM_W-1:0] s);
        case (s)
            5'd0:      return 8'h3f;
            5'd1:      return 8'h06;
            5'd2:      return 8'h5b;
            5'd3:      return 8'h4f;
            5'd4:      return 8'h66;
            5'd5:      return 8'h6d;
            5'd6:      return 8'h7d;
            5'd7:      return 8'h07;
            5'd8:      return 8'h7f;
            5'd9:      return 8'h6f;
            5'd10:     return 8'h77;
            5'd11:     return 8'h7c;
            5'd12:     return 8'h39;
            5'd13:     return 8'h5e;
            5'd14:     return 8'h79;
            5'd15:     return 8'h71;
            SYM_MINUS: return 8'h40;
            default:   return 8'h00;
        endcase
    endfunction

    function automatic bit is_ignored(input t_request r);
        return r.req == REQ_SYMBOL && r.sym >= SYM_COUNT;
    endfunction

    // Expand one request into its segment/blank frame pairs.
    task automatic predict_frames(input t_request r);
        int unsigned shown;
        int unsigned scale;
        t_frame      f;
        if (r.req == REQ_NUMBER) begin
            shown = (r.value > NUMBER_MAX) ? NUMBER_MAX : r.value;
            scale = 1000;
            for (int i = 0; i < SHOWN_DIGITS; i++) begin
                f.sel   = SEL_W'(i);
                f.seg   = segment_glyph(SYM_W'((shown / scale) % 10));
                f.blank = 1'b0;
                f.last  = 1'b0;
                frames_due.push_back(f);
                f.seg   = '0;
                f.blank = 1'b1;
                f.last  = (i == SHOWN_DIGITS - 1);
                frames_due.push_back(f);
                scale = scale / 10;
            end
        end else if (!is_ignored(r)) begin
            f.sel   = r.pos;
            f.seg   = segment_glyph(r.sym) | (r.dot ? DOT_BIT : 8'h00);
            f.blank = 1'b0;
            f.last  = 1'b0;
            frames_due.push_back(f);
            f.seg   = '0;
            f.blank = 1'b1;
            f.last  = 1'b1;
            frames_due.push_back(f);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : frame_check
        t_request r;
        t_frame   want;
        req_taken  = i_rst_n && i_valid && o_ready;
        beat_taken = i_rst_n && o_valid && i_ready;
        if (req_taken) begin
            r.req   = t_req'(i_req_type);
            r.value = i_value;
            r.pos   = i_digit_pos;
            r.sym   = i_symbol;
            r.dot   = i_dot_on;
            predict_frames(r);
        end
        if (beat_taken) begin
            if (frames_due.size() == 0) begin
                $error("unexpected beat: digit_select %0h segment_byte %0h", o_digit_select,
                       o_segment_byte);
                errors++;
            end else begin
                want = frames_due.pop_front();
                n_frames++;
                check_field("digit_select", want.sel, o_digit_select);
                check_field("segment_byte", want.seg, o_segment_byte);
                check_field("is_blank", want.blank, o_is_blank);
                check_field("last_of_run", want.last, o_last_of_run);
            end
        end
    end

    // Hold each request until accepted, then wait the drawn gap before the next.
    always @(negedge i_clk) begin : request_driver
        logic     next_valid;
        t_request r;
        next_valid = i_valid;
        if (req_taken) next_valid = 1'b0;
        if (!next_valid && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (backlog.size() > 0) begin
                r = backlog.pop_front();
                i_req_type  <= r.req;
                i_value     <= r.value;
                i_digit_pos <= r.pos;
                i_symbol    <= r.sym;
                i_dot_on    <= r.dot;
                next_valid  = 1'b1;
                gap_left    = $urandom_range(gap_cap);
            end
        end
        i_valid <= next_valid;
    end

    // Drop ready for a drawn number of cycles after each frame beat.
    always @(negedge i_clk) begin : frame_sink
        if (beat_taken) stall_left = $urandom_range(stall_cap);
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic enqueue(input t_request r);
        n_requests++;
        if (is_ignored(r)) n_ignored++;
        if (r.req == REQ_NUMBER && r.value > NUMBER_MAX) n_saturated++;
        backlog.push_back(r);
    endtask

    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        pick    = $urandom_range(99);
        r.value = VALUE_W'($urandom);
        r.pos   = SEL_W'($urandom);
        r.sym   = SYM_W'($urandom);
        r.dot   = 1'($urandom);
        if (pick < 40) begin
            r.req = REQ_NUMBER;
            case ($urandom_range(4))
                0:       r.value = VALUE_W'($urandom_range(99));
                1:       r.value = VALUE_W'($urandom_range(NUMBER_MAX));
                2:       r.value = VALUE_W'($urandom_range(NUMBER_MAX + 2, NUMBER_MAX - 8));
                3:       r.value = VALUE_W'($urandom_range(16383, NUMBER_MAX + 1));
                default: ;
            endcase
        end else if (pick < 90) begin
            r.req = REQ_SYMBOL;
            r.sym = SYM_W'($urandom_range(SYM_BLANK));
        end else begin
            r.req = REQ_SYMBOL;
            r.sym = SYM_W'($urandom_range(31, SYM_COUNT));
        end
        return r;
    endfunction

    // Wait until the sender is empty and every frame has arrived, then let the pipe settle.
    task automatic wait_idle(input int unsigned extra);
        do @(negedge i_clk);
        while (backlog.size() != 0 || i_valid || frames_due.size() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_dwell(input int unsigned cycles_held);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= DWELL_W'(cycles_held);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        n_dwell_writes++;
    endtask

    initial begin : stimulus
        int unsigned dwell_plan[5];
        int unsigned gap_plan[5];
        int unsigned stall_plan[5];
        int unsigned shown;
        t_request    r;
        dwell_plan = '{1, 2, 5, 13, 0};
        gap_plan   = '{7, 0, 0, 7, 7};
        stall_plan = '{7, 7, 0, 0, 7};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one run at the reset dwell
        enqueue('{REQ_SYMBOL, VALUE_W'(0), SEL_W'(2), SYM_W'(SYM_MINUS), 1'b1});
        wait_idle(SETTLE);

        write_dwell(0);
        enqueue('{REQ_NUMBER, VALUE_W'(0), SEL_W'(3), SYM_W'(31), 1'b1});
        enqueue('{REQ_NUMBER, VALUE_W'(NUMBER_MAX), SEL_W'(0), SYM_W'(0), 1'b0});
        enqueue('{REQ_NUMBER, VALUE_W'(NUMBER_MAX + 1), SEL_W'(1), SYM_W'(5), 1'b0});
        enqueue('{REQ_NUMBER, VALUE_W'(16383), SEL_W'(2), SYM_W'(20), 1'b1});
        enqueue('{REQ_NUMBER, VALUE_W'(907), SEL_W'(3), SYM_W'(SYM_BLANK), 1'b1});
        for (int s = 0; s <= SYM_BLANK; s++) begin
            r.req   = REQ_SYMBOL;
            r.value = VALUE_W'(16383 - s);
            r.pos   = SEL_W'(s);
            r.sym   = SYM_W'(s);
            r.dot   = 1'(s ^ (s >> 2));
            enqueue(r);
        end
        enqueue('{REQ_SYMBOL, VALUE_W'(1234), SEL_W'(1), SYM_W'(SYM_COUNT), 1'b1});
        enqueue('{REQ_SYMBOL, VALUE_W'(0), SEL_W'(3), SYM_W'(31), 1'b0});
        wait_idle(SETTLE);

        // one run at the longest dwell
        write_dwell(DWELL_MAX);
        enqueue('{REQ_SYMBOL, VALUE_W'(5555), SEL_W'(3), SYM_W'(8), 1'b1});
        wait_idle(SETTLE);

        for (int p = 0; p < 5; p++) begin
            write_dwell(dwell_plan[p]);
            gap_cap   = gap_plan[p];
            stall_cap = stall_plan[p];
            shown     = 0;
            while (shown < PER_PHASE) begin
                r = random_request();
                enqueue(r);
                if (!is_ignored(r)) shown++;
            end
            wait_idle((p == 4) ? DRAIN : SETTLE);
        end

        $display("%0d requests sent (%0d ignored, %0d saturated), %0d frames checked",
                 n_requests, n_ignored, n_saturated, n_frames);
        $display("%0d dwell settings written, including 0 and %0d", n_dwell_writes, DWELL_MAX);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
